// ===== hdl/atl_pkg.sv =====
// Shared types, widths and constants of the accelerometer tilt-angle core.
// Holds the CORDIC arctangent table, built at elaboration. No dependencies.
package atl_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int TILT_BITS       = ANGLE_FRAC_BITS + 8;
    localparam int CORDIC_STEPS    = 40;
    localparam int VEC_FRAC        = 30;
    localparam int LANES           = 3;

    // Lane order matches the result word: tilt_x, tilt_y, tilt_z.
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    // Vector datapath: sample magnitude in Q30 grows by at most the
    // CORDIC gain twice, plus sign.
    localparam int VEC_W   = SAMPLE_BITS + VEC_FRAC + 4;
    localparam int GAIN_W  = 31;
    localparam int KMAG_W  = SAMPLE_BITS + GAIN_W;
    localparam int ANG_W   = 63;
    localparam int Q30_W   = 31;
    localparam int DEGR_W  = 30;
    localparam int DEG_FRAC = 24;
    localparam int DEG_W   = Q30_W + DEGR_W;
    localparam int DEG_SHIFT = VEC_FRAC + DEG_FRAC - ANGLE_FRAC_BITS;

    // Edges from the accepting edge to the edge that takes the result.
    localparam int LATENCY = 1 + 2 * CORDIC_STEPS + 3;

    localparam logic [GAIN_W-1:0] GAIN_Q30        = 31'd1768195363;
    localparam logic [DEGR_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;
    localparam logic [63:0]       QUARTER_PI_Q60  = 64'h0C90FDAA22168C23;

    localparam logic signed [TILT_BITS-1:0] RIGHT_ANGLE =
        TILT_BITS'(90 << ANGLE_FRAC_BITS);

    // Special-case codes carried with each lane.
    localparam logic [1:0] SPEC_NONE  = 2'd0;
    localparam logic [1:0] SPEC_ZERO  = 2'd1;
    localparam logic [1:0] SPEC_RIGHT = 2'd2;
    localparam logic [1:0] SPEC_UNDEF = 2'd3;

    typedef logic signed [VEC_W-1:0]     t_vec;
    typedef logic signed [ANG_W-1:0]     t_ang;
    typedef logic signed [TILT_BITS-1:0] t_tilt;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic signed [TILT_BITS-1:0] tilt_x;
        logic signed [TILT_BITS-1:0] tilt_y;
        logic signed [TILT_BITS-1:0] tilt_z;
        logic [LANES-1:0]            undefined_mask;
    } t_result;

    typedef struct packed {
        logic       neg;
        logic [1:0] spec;
    } t_ctl;

    typedef struct packed {
        t_ctl              ctl;
        logic [KMAG_W-1:0] kmag;
    } t_tag;

    typedef logic [CORDIC_STEPS-1:0][ANG_W-1:0] t_atan_tab;

    // Restoring division of 2^sh by d, elaboration only.
    function automatic logic [63:0] pow2_div(input int sh, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        logic [63:0] num;
        num = 64'd1 << sh;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q60 from the truncated series, term by term.
    function automatic t_atan_tab build_atan_tab();
        t_atan_tab         tab;
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 e;
        tab    = '0;
        tab[0] = ANG_W'(QUARTER_PI_Q60);
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            sum = '0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                e    = i * (2 * k + 1);
                term = pow2_div(60 - e, 64'(2 * k + 1));
                if (k[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            tab[i] = ANG_W'(sum);
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan_tab();

endpackage

// ===== hdl/atl_prep.sv =====
// Input stage: magnitudes, Q30 vectors, gain-scaled lone axes and special cases.
// Depends on atl_pkg.
module atl_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  atl_pkg::t_sample i_sample,
    output logic             o_valid,
    output atl_pkg::t_vec    o_x   [atl_pkg::LANES],
    output atl_pkg::t_vec    o_y   [atl_pkg::LANES],
    output atl_pkg::t_tag    o_tag [atl_pkg::LANES]
);
    import atl_pkg::*;

    typedef logic [SAMPLE_BITS-1:0] t_mag;

    function automatic t_mag abs_mag(input logic signed [SAMPLE_BITS-1:0] v);
        return v[SAMPLE_BITS-1] ? t_mag'(~v) + t_mag'(1) : t_mag'(v);
    endfunction

    function automatic t_vec to_vec(input t_mag m);
        return VEC_W'({m, {VEC_FRAC{1'b0}}});
    endfunction

    function automatic logic [KMAG_W-1:0] k_scale(input t_mag m);
        return KMAG_W'(m) * KMAG_W'(GAIN_Q30);
    endfunction

    // atan(a / |p,q|)
    function automatic t_ctl side_ctl(input logic a_neg, input logic a_zero,
                                      input logic pq_zero);
        t_ctl c;
        c.neg = a_neg;
        if (pq_zero) begin
            c.spec = a_zero ? SPEC_UNDEF : SPEC_RIGHT;
        end else if (a_zero) begin
            c.spec = SPEC_ZERO;
        end else begin
            c.spec = SPEC_NONE;
        end
        return c;
    endfunction

    // atan(|p,q| / c)
    function automatic t_ctl top_ctl(input logic c_neg, input logic c_zero,
                                     input logic num_zero);
        t_ctl c;
        c.neg = c_neg;
        if (c_zero) begin
            c.spec = num_zero ? SPEC_UNDEF : SPEC_RIGHT;
            c.neg  = 1'b0;
        end else if (num_zero) begin
            c.spec = SPEC_ZERO;
        end else begin
            c.spec = SPEC_NONE;
        end
        return c;
    endfunction

    t_mag mag_x, mag_y, mag_z;
    logic zero_x, zero_y, zero_z;

    logic r_valid;
    t_vec r_x   [LANES];
    t_vec r_y   [LANES];
    t_tag r_tag [LANES];
    t_vec n_x   [LANES];
    t_vec n_y   [LANES];
    t_tag n_tag [LANES];

    always_comb begin
        mag_x  = abs_mag(i_sample.accel_x);
        mag_y  = abs_mag(i_sample.accel_y);
        mag_z  = abs_mag(i_sample.accel_z);
        zero_x = (mag_x == '0);
        zero_y = (mag_y == '0);
        zero_z = (mag_z == '0);

        n_x[LANE_X]      = to_vec(mag_y);
        n_y[LANE_X]      = to_vec(mag_z);
        n_tag[LANE_X].kmag = k_scale(mag_x);
        n_tag[LANE_X].ctl  = side_ctl(i_sample.accel_x[SAMPLE_BITS-1], zero_x,
                                      zero_y && zero_z);

        n_x[LANE_Y]      = to_vec(mag_x);
        n_y[LANE_Y]      = to_vec(mag_z);
        n_tag[LANE_Y].kmag = k_scale(mag_y);
        n_tag[LANE_Y].ctl  = side_ctl(i_sample.accel_y[SAMPLE_BITS-1], zero_y,
                                      zero_x && zero_z);

        n_x[LANE_Z]      = to_vec(mag_x);
        n_y[LANE_Z]      = to_vec(mag_y);
        n_tag[LANE_Z].kmag = k_scale(mag_z);
        n_tag[LANE_Z].ctl  = top_ctl(i_sample.accel_z[SAMPLE_BITS-1], zero_z,
                                     zero_x && zero_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_tag <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_tag   = r_tag;

endmodule

// ===== hdl/atl_cordic_pipe.sv =====
// Vectoring CORDIC, one micro-rotation per register stage, all lanes side by side.
// Depends on atl_pkg for widths and the arctangent table.
module atl_cordic_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  atl_pkg::t_vec i_x   [atl_pkg::LANES],
    input  atl_pkg::t_vec i_y   [atl_pkg::LANES],
    input  atl_pkg::t_tag i_tag [atl_pkg::LANES],
    output logic          o_valid,
    output atl_pkg::t_vec o_x   [atl_pkg::LANES],
    output atl_pkg::t_ang o_z   [atl_pkg::LANES],
    output atl_pkg::t_tag o_tag [atl_pkg::LANES]
);
    import atl_pkg::*;

    logic [CORDIC_STEPS-1:0] r_valid;
    logic [CORDIC_STEPS-1:0] n_valid;
    t_vec r_x   [CORDIC_STEPS][LANES];
    t_vec r_y   [CORDIC_STEPS][LANES];
    t_ang r_z   [CORDIC_STEPS][LANES];
    t_tag r_tag [CORDIC_STEPS][LANES];

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            t_vec src_x, src_y, n_x, n_y;
            t_ang src_z, n_z;
            t_tag src_tag;

            if (s == 0) begin : g_head
                assign src_x   = i_x[l];
                assign src_y   = i_y[l];
                assign src_z   = '0;
                assign src_tag = i_tag[l];
            end else begin : g_body
                assign src_x   = r_x[s-1][l];
                assign src_y   = r_y[s-1][l];
                assign src_z   = r_z[s-1][l];
                assign src_tag = r_tag[s-1][l];
            end

            // Rotate toward the x axis; shifts floor like the arithmetic model.
            always_comb begin
                if (!src_y[VEC_W-1]) begin
                    n_x = src_x + (src_y >>> s);
                    n_y = src_y - (src_x >>> s);
                    n_z = src_z + t_ang'(ATAN_TAB[s]);
                end else begin
                    n_x = src_x - (src_y >>> s);
                    n_y = src_y + (src_x >>> s);
                    n_z = src_z - t_ang'(ATAN_TAB[s]);
                end
            end

            always_ff @(posedge i_clk) begin
                r_x[s][l]   <= n_x;
                r_y[s][l]   <= n_y;
                r_z[s][l]   <= n_z;
                r_tag[s][l] <= src_tag;
            end
        end
    end

    assign n_valid = {r_valid[CORDIC_STEPS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_x[l]   = r_x[CORDIC_STEPS-1][l];
        assign o_z[l]   = r_z[CORDIC_STEPS-1][l];
        assign o_tag[l] = r_tag[CORDIC_STEPS-1][l];
    end
    assign o_valid = r_valid[CORDIC_STEPS-1];

endmodule

// ===== hdl/atl_deg_conv.sv =====
// Radians to degrees in three stages: round to Q30, scale by 180/pi, round, cap, sign.
// Depends on atl_pkg.
module atl_deg_conv (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  atl_pkg::t_ang          i_z   [atl_pkg::LANES],
    input  atl_pkg::t_ctl          i_ctl [atl_pkg::LANES],
    output logic                   o_valid,
    output atl_pkg::t_tilt         o_tilt [atl_pkg::LANES],
    output logic [atl_pkg::LANES-1:0] o_undef
);
    import atl_pkg::*;

    logic [2:0]         r_valid;
    logic [2:0]         n_valid;
    logic [Q30_W-1:0]   r_q30  [LANES];
    logic [DEG_W-1:0]   r_deg  [LANES];
    t_ctl               r_ctl1 [LANES];
    t_ctl               r_ctl2 [LANES];
    t_tilt              r_tilt [LANES];
    logic [LANES-1:0]   r_undef;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [ANG_W-1:0]     rad_pos;
        logic [ANG_W-1:0]     rad_rnd;
        logic [Q30_W-1:0]     n_q30;
        logic [DEG_W-1:0]     n_deg;
        logic [DEG_W:0]       deg_rnd;
        logic [TILT_BITS-1:0] deg_r;
        logic [TILT_BITS-1:0] mag;
        t_tilt                n_tilt;
        logic                 n_undef;

        // Stage 1: drop negative angles, round half up to Q30 radians.
        always_comb begin
            rad_pos = i_z[l][ANG_W-1] ? '0 : ANG_W'(i_z[l]);
            rad_rnd = rad_pos + (ANG_W'(1) << (VEC_FRAC - 1));
            n_q30   = rad_rnd[VEC_FRAC +: Q30_W];
        end

        // Stage 2: scale by degrees per radian.
        assign n_deg = DEG_W'(r_q30[l]) * DEG_W'(DEG_PER_RAD_Q24);

        // Stage 3: round half up, cap at ninety, apply special cases and sign.
        always_comb begin
            deg_rnd = (DEG_W + 1)'(r_deg[l]) + ((DEG_W + 1)'(1) << (DEG_SHIFT - 1));
            deg_r   = deg_rnd[DEG_SHIFT +: TILT_BITS];
            case (r_ctl2[l].spec)
                SPEC_NONE: begin
                    mag = (deg_r > $unsigned(RIGHT_ANGLE)) ? $unsigned(RIGHT_ANGLE) : deg_r;
                end
                SPEC_RIGHT: begin
                    mag = $unsigned(RIGHT_ANGLE);
                end
                default: begin
                    mag = '0;
                end
            endcase
            n_tilt  = r_ctl2[l].neg ? t_tilt'(TILT_BITS'(0) - mag) : t_tilt'(mag);
            n_undef = (r_ctl2[l].spec == SPEC_UNDEF);
        end

        always_ff @(posedge i_clk) begin
            r_q30[l]   <= n_q30;
            r_ctl1[l]  <= i_ctl[l];
            r_deg[l]   <= n_deg;
            r_ctl2[l]  <= r_ctl1[l];
            r_tilt[l]  <= n_tilt;
            r_undef[l] <= n_undef;
        end

        assign o_tilt[l] = r_tilt[l];
    end

    assign n_valid = {r_valid[1:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid[2];
    assign o_undef = r_undef;

endmodule

// ===== hdl/accel_tilt_angles_core.sv =====
// Accelerometer tilt angles: one sample (x, y, z) in, three angles in degrees out.
// Throughput: one sample per cycle; the 80 CORDIC micro-rotation stages and
// 4 conversion/input stages are all pipelined and never stall. Reset
// (synchronous, active low) clears every valid bit; busy is high during reset
// and until the ready register is set after it. The receiver cannot stall,
// so o_done is a pulse.
module accel_tilt_angles_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  atl_pkg::t_sample i_sample,
    output logic             o_done,
    output atl_pkg::t_result o_result
);
    import atl_pkg::*;

    // Hold off words until the pipeline valid bits are known clear.
    logic r_ready;
    logic accept;

    // Input stage outputs
    logic w_valid0;
    t_vec w_x0   [LANES];
    t_vec w_y0   [LANES];
    t_tag w_tag0 [LANES];

    // Pair magnitude (first CORDIC) outputs
    logic w_valid1;
    t_vec w_mag1 [LANES];
    t_tag w_tag1 [LANES];

    // Angle (second CORDIC) inputs and outputs
    t_vec w_x2   [LANES];
    t_vec w_y2   [LANES];
    logic w_valid2;
    t_ang w_ang2 [LANES];
    t_tag w_tag2 [LANES];
    t_ctl w_ctl2 [LANES];

    // Output register
    logic             w_done;
    t_tilt            w_tilt [LANES];
    logic [LANES-1:0] w_undef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy   = !r_ready;
    assign accept = start && !busy;

    // Take absolute values, scale to Q30, and flag zero numerators/denominators.
    atl_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_sample (i_sample),
        .o_valid  (w_valid0),
        .o_x      (w_x0),
        .o_y      (w_y0),
        .o_tag    (w_tag0)
    );

    // First pass: the x output is the pair magnitude times the CORDIC gain.
    // The angle of this pass is not needed.
    atl_cordic_pipe u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid0),
        .i_x     (w_x0),
        .i_y     (w_y0),
        .i_tag   (w_tag0),
        .o_valid (w_valid1),
        .o_x     (w_mag1),
        .o_z     (),
        .o_tag   (w_tag1)
    );

    // Second pass: the lone axis was scaled by the same gain, so the ratio
    // is exact. Side tilts put the magnitude on x; the z tilt puts it on y.
    for (genvar l = 0; l < LANES; l++) begin : g_route
        if (l == LANE_Z) begin : g_top
            assign w_x2[l] = VEC_W'(w_tag1[l].kmag);
            assign w_y2[l] = w_mag1[l];
        end else begin : g_side
            assign w_x2[l] = w_mag1[l];
            assign w_y2[l] = VEC_W'(w_tag1[l].kmag);
        end
        assign w_ctl2[l] = w_tag2[l].ctl;
    end

    atl_cordic_pipe u_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid1),
        .i_x     (w_x2),
        .i_y     (w_y2),
        .i_tag   (w_tag1),
        .o_valid (w_valid2),
        .o_x     (),
        .o_z     (w_ang2),
        .o_tag   (w_tag2)
    );

    // Convert Q60 radians to degrees and resolve the special cases.
    atl_deg_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid2),
        .i_z     (w_ang2),
        .i_ctl   (w_ctl2),
        .o_valid (w_done),
        .o_tilt  (w_tilt),
        .o_undef (w_undef)
    );

    assign o_done                  = w_done;
    assign o_result.tilt_x         = w_tilt[LANE_X];
    assign o_result.tilt_y         = w_tilt[LANE_Y];
    assign o_result.tilt_z         = w_tilt[LANE_Z];
    assign o_result.undefined_mask = w_undef;

    // Every accepted word comes out after exactly the pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("accepted word did not complete after pipeline latency");

    // No result without a word taken one latency earlier.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted word");

    // An undefined angle reads as zero.
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_result.undefined_mask[LANE_X] || o_result.tilt_x == '0)
                && (!o_result.undefined_mask[LANE_Y] || o_result.tilt_y == '0)
                && (!o_result.undefined_mask[LANE_Z] || o_result.tilt_z == '0))
        else $error("undefined angle is not zero");

    // Every angle stays within plus or minus ninety degrees.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.tilt_x <= RIGHT_ANGLE && o_result.tilt_x >= -RIGHT_ANGLE
                && o_result.tilt_y <= RIGHT_ANGLE && o_result.tilt_y >= -RIGHT_ANGLE
                && o_result.tilt_z <= RIGHT_ANGLE && o_result.tilt_z >= -RIGHT_ANGLE)
        else $error("tilt angle beyond ninety degrees");

endmodule

// ===== tb/tb_accel_tilt_angles_core.sv =====
// Self-checking testbench for accel_tilt_angles_core: directed and random samples
// are checked against an in-bench fixed-point CORDIC predictor of the tilt angles.
// Depends on atl_pkg (sample and result word types) and the core itself.
module tb_accel_tilt_angles_core;

    import atl_pkg::*;

    // Predictor constants: CORDIC length, vector scaling and conversion factors.
    localparam int             ROT_STEPS   = 40;
    localparam int             LEN_FRAC    = 30;
    localparam longint         GAIN_K_Q30  = 64'sd1768195363;
    localparam longint unsigned DEG_PER_RAD = 64'd961263669;
    localparam longint unsigned QUARTER_PI  = 64'h0C90FDAA22168C23;
    localparam longint unsigned FULL_TILT   = 64'd90 << ANGLE_FRAC_BITS;

    // Shapes of random sample axes.
    typedef enum {SHAPE_FULL, SHAPE_SMALL, SHAPE_SPARSE, SHAPE_CORNER} t_shape;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_sample  i_sample = '0;
    logic     o_done;
    t_result  o_result;

    // Expected result words, oldest first, and run bookkeeping.
    t_result  expected_tilts[$];
    longint   arctan_q60[ROT_STEPS];
    int       failures      = 0;
    int       samples_sent  = 0;
    int       results_seen  = 0;
    int       undef_results = 0;
    int       directed_sent = 0;

    accel_tilt_angles_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_sample (i_sample),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fill atan(2^-i) in Q60 from the truncated odd-power series; step 0 is pi/4.
    function automatic void fill_arctan();
        longint          sum;
        longint unsigned term;
        int              e;
        int              i;
        int              k;
        arctan_q60[0] = longint'(QUARTER_PI);
        for (i = 1; i < ROT_STEPS; i++) begin
            sum = 0;
            for (k = 0; i * (2 * k + 1) <= 60; k++) begin
                e    = i * (2 * k + 1);
                term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            arctan_q60[i] = sum;
        end
    endfunction

    // Vectoring rotation toward the x axis; return the swept angle in Q60 radians
    // and the gain-scaled length.
    function automatic longint vector_rotate(input longint xin, input longint yin,
                                             output longint len);
        longint xr;
        longint yr;
        longint zr;
        longint dx;
        longint dy;
        xr = xin;
        yr = yin;
        zr = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (yr >= 0) begin
                xr += dx;
                yr -= dy;
                zr += arctan_q60[i];
            end else begin
                xr -= dx;
                yr += dy;
                zr -= arctan_q60[i];
            end
        end
        len = xr;
        return zr;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Gain-scaled length of (p, q) in Q30.
    function automatic longint pair_length(input longint p, input longint q);
        longint len;
        longint ang;
        ang = vector_rotate(magnitude(p) << LEN_FRAC, magnitude(q) << LEN_FRAC, len);
        return len;
    endfunction

    // Round Q60 radians to Q30, scale to degrees, round to the angle LSB, clamp.
    function automatic longint unsigned degrees_of(input longint rad);
        longint unsigned q30;
        longint unsigned deg;
        longint unsigned r;
        q30 = (rad < 0) ? 64'd0 : (unsigned'(rad) + (64'd1 << 29)) >> 30;
        deg = q30 * DEG_PER_RAD;
        r   = (deg + (64'd1 << (53 - ANGLE_FRAC_BITS))) >> (54 - ANGLE_FRAC_BITS);
        return (r > FULL_TILT) ? FULL_TILT : r;
    endfunction

    function automatic t_tilt signed_tilt(input bit neg, input longint unsigned m);
        return t_tilt'(neg ? -m : m);
    endfunction

    // atan(a / |(p, q)|)
    function automatic t_tilt side_angle(input longint a, input longint p, input longint q,
                                         output bit undef);
        longint len;
        undef = 1'b0;
        if (p == 0 && q == 0) begin
            undef = (a == 0);
            return (a == 0) ? t_tilt'(0) : signed_tilt(a < 0, FULL_TILT);
        end
        if (a == 0) return t_tilt'(0);
        return signed_tilt(a < 0,
            degrees_of(vector_rotate(pair_length(p, q), magnitude(a) * GAIN_K_Q30, len)));
    endfunction

    // atan(|(p, q)| / c); the sign comes from c alone.
    function automatic t_tilt top_angle(input longint p, input longint q, input longint c,
                                        output bit undef);
        longint len;
        bit     flat;
        flat  = (p == 0 && q == 0);
        undef = 1'b0;
        if (c == 0) begin
            undef = flat;
            return flat ? t_tilt'(0) : signed_tilt(1'b0, FULL_TILT);
        end
        if (flat) return t_tilt'(0);
        return signed_tilt(c < 0,
            degrees_of(vector_rotate(magnitude(c) * GAIN_K_Q30, pair_length(p, q), len)));
    endfunction

    function automatic t_result predict_tilts(input t_sample s);
        t_result r;
        longint  x;
        longint  y;
        longint  z;
        bit      ux;
        bit      uy;
        bit      uz;
        x = longint'($signed(s.accel_x));
        y = longint'($signed(s.accel_y));
        z = longint'($signed(s.accel_z));
        r.tilt_x         = side_angle(x, y, z, ux);
        r.tilt_y         = side_angle(y, x, z, uy);
        r.tilt_z         = top_angle(x, y, z, uz);
        r.undefined_mask = {uz, uy, ux};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Present one sample word and hold it until an edge takes it with busy low.
    // Enter and leave at a rising edge; start stays high for the caller.
    task automatic send_xyz(input int x, input int y, input int z);
        t_sample s;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        start    <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_tilts.push_back(predict_tilts(s));
        samples_sent++;
    endtask

    // Drop start for a random stretch; pct is the idle chance per cycle.
    task automatic idle_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < pct);
        end
    endtask

    function automatic int random_axis(input t_shape shape);
        case (shape)
            SHAPE_SMALL:  return int'($urandom_range(0, 6)) - 3;
            SHAPE_SPARSE: return ($urandom_range(0, 1) == 0) ? 0
                                 : int'($signed(16'($urandom())));
            SHAPE_CORNER: begin
                case ($urandom_range(0, 5))
                    0:       return -32768;
                    1:       return -32767;
                    2:       return -1;
                    3:       return 0;
                    4:       return 1;
                    default: return 32767;
                endcase
            end
            default:      return int'($signed(16'($urandom())));
        endcase
    endfunction

    // Hit every special case: zero over zero, zero denominators of both signs,
    // zero numerators and negative z.
    task automatic test_special_cases();
        send_xyz(0, 0, 0);
        send_xyz(5, 0, 0);
        send_xyz(-5, 0, 0);
        send_xyz(0, 7, 0);
        send_xyz(0, -7, 0);
        send_xyz(0, 0, 9);
        send_xyz(0, 0, -9);
        send_xyz(3, 4, 0);
        send_xyz(-3, -4, 0);
        send_xyz(0, 0, -32768);
        send_xyz(1, -1, -1);
        send_xyz(100, -200, -300);
        directed_sent += 12;
    endtask

    // Drive the field extremes, alone and mixed.
    task automatic test_axis_extremes();
        send_xyz(32767, 32767, 32767);
        send_xyz(-32768, -32768, -32768);
        send_xyz(32767, 0, 0);
        send_xyz(-32768, 0, 0);
        send_xyz(0, 32767, 0);
        send_xyz(0, -32768, 0);
        send_xyz(0, 0, 32767);
        send_xyz(1, 1, 1);
        send_xyz(-1, -1, -1);
        send_xyz(32767, -32768, 1);
        send_xyz(-32768, 1, 32767);
        send_xyz(1, 32767, -32768);
        directed_sent += 12;
    endtask

    // Stream random samples, half full range, the rest small, sparse or at corners.
    task automatic test_random_stream(input int count, input int idle_pct);
        t_shape shape;
        int     pick;
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(0, 9);
            shape = (pick < 5) ? SHAPE_FULL : (pick < 7) ? SHAPE_SMALL :
                    (pick < 9) ? SHAPE_SPARSE : SHAPE_CORNER;
            send_xyz(random_axis(shape), random_axis(shape), random_axis(shape));
            idle_gap(idle_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: the core cannot be held off, so take every strobed word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (expected_tilts.size() == 0) begin
                $display("%0t: result %h with no sample pending", $time, o_result);
                failures++;
            end else begin
                want = expected_tilts.pop_front();
                if (want.undefined_mask != 0) undef_results++;
                if (o_result.tilt_x !== want.tilt_x) begin
                    $display("%0t: tilt_x expected %0d got %0d", $time,
                             want.tilt_x, o_result.tilt_x);
                    failures++;
                end
                if (o_result.tilt_y !== want.tilt_y) begin
                    $display("%0t: tilt_y expected %0d got %0d", $time,
                             want.tilt_y, o_result.tilt_y);
                    failures++;
                end
                if (o_result.tilt_z !== want.tilt_z) begin
                    $display("%0t: tilt_z expected %0d got %0d", $time,
                             want.tilt_z, o_result.tilt_z);
                    failures++;
                end
                if (o_result.undefined_mask !== want.undefined_mask) begin
                    $display("%0t: undefined_mask expected %b got %b", $time,
                             want.undefined_mask, o_result.undefined_mask);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed words, three random phases, drain.
    // ------------------------------------------------------------------
    initial begin
        int waited;
        fill_arctan();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_axis_extremes();
        test_random_stream(640, 0);
        test_random_stream(640, 45);
        test_random_stream(620, 20);
        start <= 1'b0;

        // Drain the pipeline, then give stray words time to show up.
        waited = 0;
        while (expected_tilts.size() != 0 && waited < 10 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
        if (expected_tilts.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_tilts.size());
            failures += expected_tilts.size();
        end

        $display("Sent %0d samples (%0d directed, rest random in three idle mixes).",
                 samples_sent, directed_sent);
        $display("Checked %0d results, %0d with an undefined flag; %0d failures.",
                 results_seen, undef_results, failures);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Stop a hung run; far beyond the slowest correct one.
    initial begin
        #2000000;
        $display("Timeout: %0d results still pending", expected_tilts.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
